/* design/btsp_pkg.sv */
// Shared types, constants and report codes for the BER-TLV sibling parser.
// No dependencies; every other design file uses it by scoped names.
`timescale 1ns / 1ps

package btsp_pkg;

	localparam int OFFSET_WIDTH     = 32;
	localparam int MAX_TAG_BYTES    = 4;
	localparam int MAX_LENGTH_BYTES = 4;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_NODE      = 2'd0;
	localparam logic [1:0] KIND_CLEAN     = 2'd1;
	localparam logic [1:0] KIND_MALFORMED = 2'd2;

	localparam logic [2:0] CAUSE_NONE        = 3'd0;
	localparam logic [2:0] CAUSE_BAD_TAG     = 3'd1;
	localparam logic [2:0] CAUSE_TAG_LONG    = 3'd2;
	localparam logic [2:0] CAUSE_BAD_LEN     = 3'd3;
	localparam logic [2:0] CAUSE_LEN_LONG    = 3'd4;
	localparam logic [2:0] CAUSE_TRUNCATED   = 3'd5;

	localparam logic [7:0] BYTE_PAD      = 8'h00;
	localparam logic [7:0] BYTE_RESERVED = 8'hFF;
	localparam logic [7:0] BYTE_INDEF    = 8'h80;
	localparam logic [7:0] MASK_CONS     = 8'h20;
	localparam logic [7:0] MASK_HIGH_TAG = 8'h1F;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  report_kind;
		logic [31:0] node_tag;
		logic        is_constructed;
		logic [31:0] value_length;
		logic [31:0] node_start;
		logic [31:0] value_start;
		logic        tag_match;
		logic [2:0]  error_cause;
		logic        final_report;
	} out_word_t;

	// Reports produced by one byte: none, one, or two (node then final).
	typedef struct packed {
		logic [1:0] count;
		out_word_t  first;
		out_word_t  second;
	} step_res_t;

endpackage

/* design/btsp_parser.sv */
// Parse state and per-byte next-state logic; emits up to two reports per byte.
// Depends on btsp_pkg.
`timescale 1ns / 1ps

module btsp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  btsp_pkg::in_word_t  word,
	input  logic [31:0]         target_tag,
	output btsp_pkg::step_res_t res
);

	typedef enum logic [2:0] {
		PH_TAG_FIRST,
		PH_TAG_MORE,
		PH_LEN_FIRST,
		PH_LEN_MORE,
		PH_VALUE
	} phase_t;

	localparam int OW = btsp_pkg::OFFSET_WIDTH;

	phase_t          phase_q, phase_n;
	logic [31:0]     tag_q, tag_n;
	logic [2:0]      tag_cnt_q, tag_cnt_n;
	logic            cons_q, cons_n;
	logic [31:0]     len_q, len_n;
	logic [2:0]      len_left_q, len_left_n;
	logic [31:0]     val_left_q, val_left_n;
	logic [OW-1:0]   pos_q, pos_n;
	logic [OW-1:0]   node_off_q, node_off_n;
	logic [OW-1:0]   val_off_q, val_off_n;
	logic            failed_q, failed_n;

	logic [7:0]      b;
	logic [OW-1:0]   pos_next;
	logic [2:0]      cause;
	logic            done;
	logic            clear;
	btsp_pkg::out_word_t node_rep, err_rep, fin_rep;

	assign b        = word.data_byte;
	assign pos_next = pos_q + OW'(1);

	always_comb begin
		phase_n    = phase_q;
		tag_n      = tag_q;
		tag_cnt_n  = tag_cnt_q;
		cons_n     = cons_q;
		len_n      = len_q;
		len_left_n = len_left_q;
		val_left_n = val_left_q;
		node_off_n = node_off_q;
		val_off_n  = val_off_q;
		cause      = btsp_pkg::CAUSE_NONE;
		done       = 1'b0;

		unique case (phase_q)
			PH_TAG_FIRST: begin
				node_off_n = pos_q;
				if (b == btsp_pkg::BYTE_PAD || b == btsp_pkg::BYTE_RESERVED) begin
					cause = btsp_pkg::CAUSE_BAD_TAG;
				end else begin
					cons_n    = (b & btsp_pkg::MASK_CONS) != 8'h00;
					tag_n     = {24'h0, b};
					tag_cnt_n = 3'd1;
					if ((b & btsp_pkg::MASK_HIGH_TAG) == btsp_pkg::MASK_HIGH_TAG) begin
						if (btsp_pkg::MAX_TAG_BYTES <= 1)
							cause = btsp_pkg::CAUSE_TAG_LONG;
						else
							phase_n = PH_TAG_MORE;
					end else begin
						phase_n = PH_LEN_FIRST;
					end
				end
			end
			PH_TAG_MORE: begin
				tag_n     = {tag_q[23:0], b};
				tag_cnt_n = tag_cnt_q + 3'd1;
				if (b[7]) begin
					if (tag_cnt_n >= 3'(btsp_pkg::MAX_TAG_BYTES))
						cause = btsp_pkg::CAUSE_TAG_LONG;
				end else begin
					phase_n = PH_LEN_FIRST;
				end
			end
			PH_LEN_FIRST: begin
				if (!b[7]) begin
					len_n     = {24'h0, b};
					val_off_n = pos_next;
					if (b == 8'h00) begin
						done = 1'b1;
					end else begin
						val_left_n = {24'h0, b};
						phase_n    = PH_VALUE;
					end
				end else if (b == btsp_pkg::BYTE_INDEF || b == btsp_pkg::BYTE_RESERVED) begin
					cause = btsp_pkg::CAUSE_BAD_LEN;
				end else if (b[6:0] > 7'(btsp_pkg::MAX_LENGTH_BYTES)) begin
					cause = btsp_pkg::CAUSE_LEN_LONG;
				end else begin
					len_n      = 32'h0;
					len_left_n = b[2:0];
					phase_n    = PH_LEN_MORE;
				end
			end
			PH_LEN_MORE: begin
				len_n      = {len_q[23:0], b};
				len_left_n = len_left_q - 3'd1;
				if (len_left_n == 3'd0) begin
					val_off_n = pos_next;
					if (len_n == 32'h0) begin
						done = 1'b1;
					end else begin
						val_left_n = len_n;
						phase_n    = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				val_left_n = val_left_q - 32'd1;
				if (val_left_n == 32'h0)
					done = 1'b1;
			end
			default: begin
				phase_n = PH_TAG_FIRST;
			end
		endcase

		if (done)
			phase_n = PH_TAG_FIRST;
	end

	always_comb begin
		node_rep                = '0;
		node_rep.report_kind    = btsp_pkg::KIND_NODE;
		node_rep.node_tag       = tag_n;
		node_rep.is_constructed = cons_n;
		node_rep.value_length   = len_n;
		node_rep.node_start     = 32'(node_off_n);
		node_rep.value_start    = 32'(val_off_n);
		node_rep.tag_match      = tag_n == target_tag;

		err_rep              = '0;
		err_rep.report_kind  = btsp_pkg::KIND_MALFORMED;
		err_rep.node_start   = failed_q ? 32'(node_off_q) : 32'(node_off_n);
		err_rep.error_cause  = failed_q ? btsp_pkg::CAUSE_NONE : cause;
		err_rep.final_report = word.last_byte;

		fin_rep              = '0;
		fin_rep.final_report = 1'b1;
		if (phase_n == PH_TAG_FIRST) begin
			fin_rep.report_kind = btsp_pkg::KIND_CLEAN;
		end else begin
			fin_rep.report_kind = btsp_pkg::KIND_MALFORMED;
			fin_rep.node_start  = 32'(node_off_n);
			fin_rep.error_cause = btsp_pkg::CAUSE_TRUNCATED;
		end

		res        = '0;
		failed_n   = failed_q;
		pos_n      = pos_next;
		clear      = word.last_byte;
		if (failed_q) begin
			// drop bytes until the last one closes out the buffer
			res.count = {1'b0, word.last_byte};
			res.first = err_rep;
		end else if (cause != btsp_pkg::CAUSE_NONE) begin
			res.count = 2'd1;
			res.first = err_rep;
			failed_n  = 1'b1;
		end else if (done) begin
			res.count  = word.last_byte ? 2'd2 : 2'd1;
			res.first  = node_rep;
			res.second = fin_rep;
		end else begin
			res.count = {1'b0, word.last_byte};
			res.first = fin_rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG_FIRST;
			tag_q      <= '0;
			tag_cnt_q  <= '0;
			cons_q     <= 1'b0;
			len_q      <= '0;
			len_left_q <= '0;
			val_left_q <= '0;
			pos_q      <= '0;
			node_off_q <= '0;
			val_off_q  <= '0;
			failed_q   <= 1'b0;
		end else if (step) begin
			if (clear) begin
				phase_q    <= PH_TAG_FIRST;
				tag_q      <= '0;
				tag_cnt_q  <= '0;
				cons_q     <= 1'b0;
				len_q      <= '0;
				len_left_q <= '0;
				val_left_q <= '0;
				pos_q      <= '0;
				node_off_q <= '0;
				val_off_q  <= '0;
				failed_q   <= 1'b0;
			end else if (failed_q) begin
				// hold parse state while dropping; only the offset advances
				pos_q <= pos_n;
			end else begin
				phase_q    <= phase_n;
				tag_q      <= tag_n;
				tag_cnt_q  <= tag_cnt_n;
				cons_q     <= cons_n;
				len_q      <= len_n;
				len_left_q <= len_left_n;
				val_left_q <= val_left_n;
				pos_q      <= pos_n;
				node_off_q <= node_off_n;
				val_off_q  <= val_off_n;
				failed_q   <= failed_n;
			end
		end
	end

endmodule

/* design/btsp_queue.sv */
// Small report queue: takes up to two reports a cycle, hands out one while not stalled.
// Depends on btsp_pkg.
`timescale 1ns / 1ps

module btsp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  btsp_pkg::step_res_t  res,
	output logic                 room,
	output logic                 valid,
	input  logic                 stall,
	output btsp_pkg::out_word_t  word
);

	localparam int PW = btsp_pkg::QUEUE_PTR_W;

	btsp_pkg::out_word_t   mem_q [btsp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]         wr_q, rd_q;
	logic [PW:0]           cnt_q;
	logic [1:0]            n_push;
	logic                  pop;

	assign n_push = push ? res.count : 2'd0;
	assign pop    = valid && !stall;
	assign valid  = cnt_q != '0;
	// keep space for a node report plus its final report
	assign room   = cnt_q <= (PW+1)'(btsp_pkg::QUEUE_DEPTH - 2);
	assign word   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_q] <= res.first;
		if (n_push == 2'd2)
			mem_q[wr_q + PW'(1)] <= res.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(n_push);
			if (pop)
				rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(n_push) - (PW+1)'(pop);
		end
	end

endmodule

/* design/ber_tlv_sibling_parser.sv */
// A report is offered from the report queue once it has been registered there.
// Throughput: one byte per cycle while the report queue has room; a last byte that closes a node
// yields two reports, handed out in order from a four-entry report queue.
// Reset (arst_n low) clears parse state, target tag and the report queue.
// Top level of the BER-TLV sibling parser; uses btsp_pkg, btsp_parser,
// btsp_queue.
`timescale 1ns / 1ps

module ber_tlv_sibling_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  btsp_pkg::in_word_t  byte_word,
	output logic                report_valid,
	input  logic                report_stall,
	output btsp_pkg::out_word_t report_word
);

	logic [31:0]          target_tag_q;
	logic                 room;
	logic                 step;
	btsp_pkg::step_res_t  res;

	assign byte_stall = !room;
	assign step       = byte_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_tag_q <= '0;
		end else if (cfg_we) begin
			target_tag_q <= cfg_wdata;
		end
	end

	btsp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.word       (byte_word),
		.target_tag (target_tag_q),
		.res        (res)
	);

	btsp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.res    (res),
		.room   (room),
		.valid  (report_valid),
		.stall  (report_stall),
		.word   (report_word)
	);

endmodule

/* design/btsp_checker.sv */
// Port-level checks on the report channel of the BER-TLV sibling parser.
// Depends on btsp_pkg; bound to ber_tlv_sibling_parser.
`timescale 1ns / 1ps

module btsp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                report_valid,
	input logic                report_stall,
	input btsp_pkg::out_word_t report_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_stall |=> report_valid && $stable(report_word))
		else $error("report word changed while stalled");

	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_word.report_kind == btsp_pkg::KIND_CLEAN |->
		report_word.final_report && report_word.error_cause == btsp_pkg::CAUSE_NONE
		&& report_word.node_tag == 32'h0 && report_word.node_start == 32'h0)
		else $error("clean end report carries stray fields");

	a_node: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_word.report_kind == btsp_pkg::KIND_NODE |->
		!report_word.final_report && report_word.error_cause == btsp_pkg::CAUSE_NONE)
		else $error("node report marked final or with an error");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_word.report_kind == btsp_pkg::KIND_MALFORMED
		&& report_word.error_cause == btsp_pkg::CAUSE_NONE |->
		report_word.final_report)
		else $error("malformed report without cause is not final");

endmodule

bind ber_tlv_sibling_parser btsp_checker u_btsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.report_valid (report_valid),
	.report_stall (report_stall),
	.report_word  (report_word)
);

/* tb/sv/ber_tlv_sibling_parser_tb.sv */
// Self-checking testbench for ber_tlv_sibling_parser: feeds directed and random TLV buffers,
// predicts every report in a scoreboard class and checks each report field by field.
// Depends on btsp_pkg and the ber_tlv_sibling_parser RTL only.
`timescale 1ns / 1ps

module ber_tlv_sibling_parser_tb;
	import btsp_pkg::*;

	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_WAIT     = 2000;
	localparam int LONG_HOLD    = 80;
	localparam int PHASE_BYTES  = 125;

	typedef enum logic [2:0] {
		PH_TAG_FIRST,
		PH_TAG_MORE,
		PH_LEN_FIRST,
		PH_LEN_MORE,
		PH_VALUE
	} parse_step_e;

	class tlv_scoreboard;
		out_word_t   expect_q[$];
		logic [31:0] target_tag;
		parse_step_e step;
		logic [31:0] tag_acc;
		int unsigned tag_count;
		logic        cons_flag;
		logic [31:0] len_acc;
		int unsigned len_left;
		logic [31:0] value_left;
		logic [31:0] byte_pos;
		logic [31:0] node_at;
		logic [31:0] value_at;
		logic        dropping;
		int unsigned n_bytes, n_parsed, n_checked, n_nodes, n_hits, n_clean, n_malformed;
		int unsigned n_fail;

		function new();
			clear_buffer();
			target_tag = '0;
		endfunction

		function void clear_buffer();
			step       = PH_TAG_FIRST;
			tag_acc    = '0;
			tag_count  = 0;
			cons_flag  = 1'b0;
			len_acc    = '0;
			len_left   = 0;
			value_left = '0;
			byte_pos   = '0;
			node_at    = '0;
			value_at   = '0;
			dropping   = 1'b0;
		endfunction

		function void set_target(logic [31:0] value);
			target_tag = value;
		endfunction

		function int unsigned pending();
			return expect_q.size();
		endfunction

		function void push_report(logic [1:0] kind, logic [31:0] tag, logic cons,
				logic [31:0] len, logic [31:0] ns, logic [31:0] vs, logic hit,
				logic [2:0] cause, logic fin);
			out_word_t r;
			r.report_kind    = kind;
			r.node_tag       = tag;
			r.is_constructed = cons;
			r.value_length   = len;
			r.node_start     = ns;
			r.value_start    = vs;
			r.tag_match      = hit;
			r.error_cause    = cause;
			r.final_report   = fin;
			expect_q.push_back(r);
		endfunction

		function void note_input(in_word_t w);
			logic [7:0]  b;
			logic        fin_in;
			logic [31:0] pos_next;
			logic [2:0]  cause;
			bit          done;
			b        = w.data_byte;
			fin_in   = w.last_byte;
			pos_next = byte_pos + 32'd1;
			cause    = CAUSE_NONE;
			done     = 1'b0;
			n_bytes++;
			// after an error, drop everything up to the last byte
			if (dropping) begin
				if (fin_in) begin
					push_report(KIND_MALFORMED, '0, 1'b0, '0, node_at, '0, 1'b0, CAUSE_NONE, 1'b1);
					clear_buffer();
				end else begin
					byte_pos = pos_next;
				end
				return;
			end
			n_parsed++;
			case (step)
				PH_TAG_FIRST: begin
					node_at = byte_pos;
					if (b == BYTE_PAD || b == BYTE_RESERVED) begin
						cause = CAUSE_BAD_TAG;
					end else begin
						cons_flag = ((b & MASK_CONS) != 0);
						tag_acc   = {24'd0, b};
						tag_count = 1;
						if ((b & MASK_HIGH_TAG) == MASK_HIGH_TAG) begin
							if (tag_count >= MAX_TAG_BYTES) cause = CAUSE_TAG_LONG;
							else step = PH_TAG_MORE;
						end else begin
							step = PH_LEN_FIRST;
						end
					end
				end
				PH_TAG_MORE: begin
					tag_acc   = {tag_acc[23:0], b};
					tag_count = tag_count + 1;
					if (b[7]) begin
						if (tag_count >= MAX_TAG_BYTES) cause = CAUSE_TAG_LONG;
					end else begin
						step = PH_LEN_FIRST;
					end
				end
				PH_LEN_FIRST: begin
					if (b < BYTE_INDEF) begin
						len_acc  = {24'd0, b};
						value_at = pos_next;
						if (b == 8'd0) begin
							done = 1'b1;
						end else begin
							value_left = {24'd0, b};
							step       = PH_VALUE;
						end
					end else if (b == BYTE_INDEF || b == BYTE_RESERVED) begin
						cause = CAUSE_BAD_LEN;
					end else if (b[6:0] > MAX_LENGTH_BYTES) begin
						cause = CAUSE_LEN_LONG;
					end else begin
						len_acc  = '0;
						len_left = b[6:0];
						step     = PH_LEN_MORE;
					end
				end
				PH_LEN_MORE: begin
					len_acc  = {len_acc[23:0], b};
					len_left = len_left - 1;
					if (len_left == 0) begin
						value_at = pos_next;
						if (len_acc == 0) begin
							done = 1'b1;
						end else begin
							value_left = len_acc;
							step       = PH_VALUE;
						end
					end
				end
				default: begin
					value_left = value_left - 32'd1;
					if (value_left == 0) done = 1'b1;
				end
			endcase

			if (cause != CAUSE_NONE) begin
				push_report(KIND_MALFORMED, '0, 1'b0, '0, node_at, '0, 1'b0, cause, fin_in);
				if (fin_in) begin
					clear_buffer();
				end else begin
					dropping = 1'b1;
					byte_pos = pos_next;
				end
				return;
			end
			if (done) begin
				push_report(KIND_NODE, tag_acc, cons_flag, len_acc, node_at, value_at,
					tag_acc == target_tag, CAUSE_NONE, 1'b0);
				step = PH_TAG_FIRST;
			end
			if (fin_in) begin
				if (step == PH_TAG_FIRST)
					push_report(KIND_CLEAN, '0, 1'b0, '0, '0, '0, 1'b0, CAUSE_NONE, 1'b1);
				else
					push_report(KIND_MALFORMED, '0, 1'b0, '0, node_at, '0, 1'b0,
						CAUSE_TRUNCATED, 1'b1);
				clear_buffer();
			end else begin
				byte_pos = pos_next;
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				n_fail++;
			end
		endfunction

		function void check_result(out_word_t r);
			out_word_t want;
			n_checked++;
			if (expect_q.size() == 0) begin
				$error("report with nothing expected: kind %0d cause %0d", r.report_kind,
					r.error_cause);
				n_fail++;
				return;
			end
			want = expect_q.pop_front();
			compare("report_kind", want.report_kind, r.report_kind);
			compare("node_tag", want.node_tag, r.node_tag);
			compare("is_constructed", want.is_constructed, r.is_constructed);
			compare("value_length", want.value_length, r.value_length);
			compare("node_start", want.node_start, r.node_start);
			compare("value_start", want.value_start, r.value_start);
			compare("tag_match", want.tag_match, r.tag_match);
			compare("error_cause", want.error_cause, r.error_cause);
			compare("final_report", want.final_report, r.final_report);
			case (want.report_kind)
				KIND_NODE: begin
					n_nodes++;
					if (want.tag_match) n_hits++;
				end
				KIND_CLEAN: n_clean++;
				default: n_malformed++;
			endcase
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [31:0] cfg_wdata    = '0;
	logic        byte_valid   = 1'b0;
	logic        byte_stall;
	in_word_t    byte_word    = '0;
	logic        report_valid;
	logic        report_stall = 1'b0;
	out_word_t   report_word;

	tlv_scoreboard sb;
	logic [7:0]    frame_q[$];
	logic [31:0]   tag_pool[4];
	int            tag_size[4];
	int            burst_left   = 0;
	bit            hold_request = 1'b0;
	int unsigned   n_targets    = 0;
	int unsigned   cycle_count  = 0;

	ber_tlv_sibling_parser uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_word   (byte_word),
		.report_valid(report_valid),
		.report_stall(report_stall),
		.report_word (report_word)
	);

	always #4 clk = ~clk;

	initial sb = new();

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) sb.note_input(byte_word);
			if (report_valid && !report_stall) sb.check_result(report_word);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d reports outstanding", cycle_count,
				sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: stretches of varying stall density, plus an occasional long hold-off.
	initial begin
		int stretch;
		int mode;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				report_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stretch = $urandom_range(4, 40);
				mode    = $urandom_range(0, 3);
				for (int i = 0; i < stretch; i++) begin
					case (mode)
						0: report_stall <= 1'b0;
						1: report_stall <= ($urandom_range(0, 3) == 0);
						2: report_stall <= ($urandom_range(0, 1) == 0);
						default: report_stall <= (i % 3 != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Drive the frame out one word per handshake, in bursts that are usually separated by gaps.
	task automatic send_frame();
		in_word_t w;
		int       gap;
		while (frame_q.size() > 0) begin
			w.data_byte = frame_q.pop_front();
			w.last_byte = (frame_q.size() == 0);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					byte_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			byte_word  <= w;
			byte_valid <= 1'b1;
			@(posedge clk);
			while (byte_stall) @(posedge clk);
		end
	endtask

	// Let the monitor note the last accepted word before looking at the scoreboard.
	task automatic wait_idle();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input logic [31:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_target(value);
		n_targets++;
	endtask

	function automatic logic [31:0] make_tag(int nb);
		logic [31:0] tag;
		logic [7:0]  b;
		if (nb == 1) begin
			do b = 8'($urandom_range(1, 254));
			while ((b & MASK_HIGH_TAG) == MASK_HIGH_TAG);
			return {24'd0, b};
		end
		// high-tag form: continuation bytes carry bit 7, the closing byte clears it
		tag = {24'd0, 3'($urandom_range(0, 6)), 5'h1F};
		for (int i = 1; i < nb; i++) begin
			b = 8'($urandom);
			b[7] = (i != nb - 1);
			tag = {tag[23:0], b};
		end
		return tag;
	endfunction

	function automatic void new_pool();
		for (int i = 0; i < 4; i++) begin
			tag_size[i] = i + 1;
			tag_pool[i] = make_tag(i + 1);
		end
	endfunction

	function automatic void put_length(int unsigned len);
		int nb;
		if (len < 128 && $urandom_range(0, 2) != 0) begin
			frame_q.push_back(8'(len));
		end else begin
			nb = $urandom_range((len > 255) ? 2 : 1, MAX_LENGTH_BYTES);
			frame_q.push_back(8'h80 | 8'(nb));
			for (int i = nb - 1; i >= 0; i--) frame_q.push_back(8'(len >> (8 * i)));
		end
	endfunction

	function automatic void put_node();
		logic [31:0] tag;
		int          nb;
		int          idx;
		int          r;
		int unsigned len;
		if ($urandom_range(0, 3) != 0) begin
			idx = $urandom_range(0, 3);
			tag = tag_pool[idx];
			nb  = tag_size[idx];
		end else begin
			nb  = $urandom_range(1, MAX_TAG_BYTES);
			tag = make_tag(nb);
		end
		for (int i = nb - 1; i >= 0; i--) frame_q.push_back(tag[8 * i +: 8]);
		r = $urandom_range(0, 59);
		if (r == 0)      len = $urandom_range(128, 260);
		else if (r < 6)  len = 0;
		else if (r < 50) len = $urandom_range(1, 6);
		else             len = $urandom_range(7, 40);
		put_length(len);
		repeat (len) frame_q.push_back(8'($urandom));
	endfunction

	function automatic logic [7:0] bad_byte();
		case ($urandom_range(0, 6))
			0: return BYTE_PAD;
			1: return BYTE_RESERVED;
			2: return BYTE_INDEF;
			3: return 8'h80 | 8'($urandom_range(MAX_LENGTH_BYTES + 1, 127));
			4: return 8'h9F;
			5: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed buffers; the rest are cut short, corrupted or plain noise.
	function automatic void random_frame();
		int sel;
		int keep;
		sel = $urandom_range(0, 99);
		if (sel < 94) begin
			repeat ($urandom_range(1, 4)) put_node();
			if (sel >= 72 && sel < 84 && frame_q.size() > 1) begin
				keep = $urandom_range(1, frame_q.size() - 1);
				while (frame_q.size() > keep) void'(frame_q.pop_back());
			end else if (sel >= 84) begin
				frame_q[$urandom_range(0, frame_q.size() - 1)] = bad_byte();
			end
		end else begin
			repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom));
		end
	endfunction

	task automatic random_phase(int unsigned quota);
		int unsigned start;
		start = sb.n_bytes;
		while (sb.n_bytes - start < quota) begin
			random_frame();
			send_frame();
		end
	endtask

	initial begin
		int waited;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		write_target(32'hDFFF_FF7F);
		frame_q = '{8'h00};
		send_frame();
		frame_q = '{8'hFF, 8'h12};
		send_frame();
		frame_q = '{8'hDF, 8'h81, 8'h82, 8'h83};
		send_frame();
		frame_q = '{8'h04, 8'h80};
		send_frame();
		frame_q = '{8'h24, 8'h85};
		send_frame();
		frame_q = '{8'h30, 8'h00, 8'hDF, 8'hFF, 8'hFF, 8'h7F, 8'h84, 8'h00, 8'h00, 8'h00,
			8'h01, 8'hEE};
		send_frame();
		frame_q = '{8'h04, 8'h83, 8'hFF, 8'hFF};
		send_frame();

		new_pool();
		write_target(tag_pool[0]);
		hold_request = 1'b1;
		random_phase(PHASE_BYTES);

		new_pool();
		write_target(32'hFFFF_FFFF);
		random_phase(PHASE_BYTES);

		new_pool();
		write_target(32'h0000_0000);
		hold_request = 1'b1;
		random_phase(PHASE_BYTES);

		new_pool();
		write_target(tag_pool[$urandom_range(0, 3)]);
		random_phase(PHASE_BYTES);

		byte_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (sb.pending() != 0 && waited < END_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected reports never arrived", sb.pending());
			sb.n_fail += sb.pending();
		end

		$display("Fed %0d bytes (%0d parsed) under %0d target tags; checked %0d reports.",
			sb.n_bytes, sb.n_parsed, n_targets, sb.n_checked);
		$display("Reports seen: %0d nodes (%0d tag hits), %0d clean ends, %0d malformed.",
			sb.n_nodes, sb.n_hits, sb.n_clean, sb.n_malformed);
		if (sb.n_fail == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
